[hw/rtl/olist_pkg.sv]
// package: command, status and cell control codes for the ordered list engine
`timescale 1ns / 1ps

package olist_pkg;

   // command codes
   localparam logic [2:0] OP_INS_HEAD = 3'd0;
   localparam logic [2:0] OP_INS_TAIL = 3'd1;
   localparam logic [2:0] OP_INS_AT   = 3'd2;
   localparam logic [2:0] OP_DEL_HEAD = 3'd3;
   localparam logic [2:0] OP_DEL_TAIL = 3'd4;
   localparam logic [2:0] OP_DEL_AT   = 3'd5;
   localparam logic [2:0] OP_SEARCH   = 3'd6;
   localparam logic [2:0] OP_DISPLAY  = 3'd7;

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_RANGE    = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   // what every cell does in a cycle
   localparam logic [1:0] MODE_HOLD = 2'd0;
   localparam logic [1:0] MODE_INS  = 2'd1;
   localparam logic [1:0] MODE_DEL  = 2'd2;
   localparam logic [1:0] MODE_ROT  = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] value;
   } cell_ctl_type;

endpackage

[hw/rtl/olist_cell.sv]
// one storage cell of the list: holds one value, shifts with its neighbors
`timescale 1ns / 1ps

module olist_cell #(
   parameter int CAPACITY = 16,
   parameter int INDEX    = 0
) (
   input  logic                           clock,
   input  olist_pkg::cell_ctl_type        ctl,
   input  logic [$clog2(CAPACITY)-1:0]    idx,
   input  logic [$clog2(CAPACITY+1)-1:0]  count,
   input  logic [31:0]                    prev_value,
   input  logic [31:0]                    next_value,
   input  logic [31:0]                    wrap_value,
   output logic [31:0]                    value,
   output logic                           match
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] MY_NEXT  = CNT_W'(INDEX + 1);

   logic [31:0]      value_ff;
   logic [31:0]      value_in;
   logic [CNT_W-1:0] idx_ext;
   logic             in_use;

   assign idx_ext = CNT_W'(idx);
   assign in_use  = MY_INDEX < count;

   always_comb begin
      value_in = value_ff;
      unique case (ctl.mode)
         olist_pkg::MODE_INS: begin
            if (MY_INDEX == idx_ext) begin
               value_in = ctl.value;
            end else if (MY_INDEX > idx_ext) begin
               value_in = prev_value;
            end
         end
         olist_pkg::MODE_DEL: begin
            if (MY_INDEX >= idx_ext) begin
               value_in = next_value;
            end
         end
         olist_pkg::MODE_ROT: begin
            // rotate the used part of the row one place toward the head
            if (MY_NEXT == count) begin
               value_in = wrap_value;
            end else if (in_use) begin
               value_in = next_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign match = in_use && (value_ff == ctl.value);

endmodule

[hw/rtl/ordered_list_engine_top.sv]
// top level: command decode, row of list cells, result register and display walk
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells
// that shift toward the tail on insert and toward the head on delete, all in
// parallel. Insert, delete and search each give one item on the rsp_ channel
// from a registered result; a new command can be taken every cycle while the
// result register is free or being drained. Display of N entries rotates the
// row one place per cycle while the output is free and gives N items (one
// item with status empty when the list is empty), holding off further
// commands until the walk ends, after which the row is back in its original order.
module ordered_list_engine_top #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic signed [31:0] req_value,
   input  logic [7:0]  req_position,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic signed [31:0] rsp_value_out,
   output logic [6:0]  rsp_position_out,
   output logic        rsp_last
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   // list state
   logic [CNT_W-1:0] count_ff, count_in;
   logic             disp_ff, disp_in;
   logic [CNT_W-1:0] disp_cnt_ff, disp_cnt_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  status_ff, status_in;
   logic [31:0] value_ff, value_in;
   logic [6:0]  position_ff, position_in;
   logic        last_ff, last_in;

   logic out_free;
   logic accept;

   olist_pkg::cell_ctl_type ctl;
   logic [IDX_W-1:0] cell_idx;
   logic [31:0]      cell_value [CAPACITY];
   logic [CAPACITY-1:0] cell_match;

   logic [8:0]       pos_ext;
   logic [8:0]       count_ext;
   logic             list_full;
   logic             list_empty;
   logic [IDX_W-1:0] ins_idx;
   logic [IDX_W-1:0] del_idx;
   logic [31:0]      taken_value;
   logic [IDX_W-1:0] found_idx;
   logic             found;
   logic             ins_pos_ok;
   logic             del_pos_ok;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !disp_ff && out_free;
   assign accept     = req_valid && req_ready;

   assign pos_ext    = {1'b0, req_position};
   assign count_ext  = 9'(count_ff);
   assign list_full  = count_ff == FULL_COUNT;
   assign list_empty = count_ff == '0;
   assign ins_pos_ok = (pos_ext != 9'd0) && (pos_ext <= count_ext + 9'd1);
   assign del_pos_ok = (pos_ext != 9'd0) && (pos_ext <= count_ext);

   always_comb begin
      unique case (req_op)
         olist_pkg::OP_INS_HEAD: ins_idx = '0;
         olist_pkg::OP_INS_TAIL: ins_idx = IDX_W'(count_ff);
         default:                ins_idx = IDX_W'(pos_ext - 9'd1);
      endcase
      unique case (req_op)
         olist_pkg::OP_DEL_HEAD: del_idx = '0;
         olist_pkg::OP_DEL_TAIL: del_idx = IDX_W'(count_ff - CNT_W'(1));
         default:                del_idx = IDX_W'(pos_ext - 9'd1);
      endcase
   end

   // value held at the delete slot, one-hot select over the row
   always_comb begin
      taken_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (del_idx == IDX_W'(i)) begin
            taken_value = taken_value | cell_value[i];
         end
      end
   end

   // first matching cell from the head
   always_comb begin
      found_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (cell_match[i]) begin
            found_idx = IDX_W'(i);
         end
      end
      found = |cell_match;
   end

   always_comb begin
      ctl.mode     = olist_pkg::MODE_HOLD;
      ctl.value    = req_value;
      cell_idx     = ins_idx;
      count_in     = count_ff;
      disp_in      = disp_ff;
      disp_cnt_in  = disp_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      value_in     = value_ff;
      position_in  = position_ff;
      last_in      = last_ff;

      if (disp_ff) begin
         if (out_free) begin
            ctl.mode     = olist_pkg::MODE_ROT;
            rsp_valid_in = 1'b1;
            status_in    = olist_pkg::ST_OK;
            value_in     = cell_value[0];
            position_in  = 7'(disp_cnt_ff + CNT_W'(1));
            last_in      = (disp_cnt_ff + CNT_W'(1)) == count_ff;
            disp_cnt_in  = disp_cnt_ff + CNT_W'(1);
            if ((disp_cnt_ff + CNT_W'(1)) == count_ff) begin
               disp_in = 1'b0;
            end
         end
      end else if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = olist_pkg::ST_OK;
         value_in     = '0;
         position_in  = '0;
         last_in      = 1'b1;
         unique case (req_op)
            olist_pkg::OP_INS_HEAD, olist_pkg::OP_INS_TAIL, olist_pkg::OP_INS_AT: begin
               if ((req_op == olist_pkg::OP_INS_AT) && !ins_pos_ok) begin
                  status_in = olist_pkg::ST_RANGE;
               end else if (list_full) begin
                  status_in = olist_pkg::ST_FULL;
               end else begin
                  ctl.mode = olist_pkg::MODE_INS;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            olist_pkg::OP_DEL_HEAD, olist_pkg::OP_DEL_TAIL, olist_pkg::OP_DEL_AT: begin
               cell_idx = del_idx;
               if (list_empty) begin
                  status_in = olist_pkg::ST_EMPTY;
               end else if ((req_op == olist_pkg::OP_DEL_AT) && !del_pos_ok) begin
                  status_in = olist_pkg::ST_RANGE;
               end else begin
                  ctl.mode = olist_pkg::MODE_DEL;
                  count_in = count_ff - CNT_W'(1);
                  value_in = taken_value;
               end
            end
            olist_pkg::OP_SEARCH: begin
               if (found) begin
                  value_in    = req_value;
                  position_in = 7'(found_idx) + 7'd1;
               end else begin
                  status_in = olist_pkg::ST_NOTFOUND;
               end
            end
            default: begin
               // display: walk begins next cycle, no item now unless list empty
               if (list_empty) begin
                  status_in = olist_pkg::ST_EMPTY;
               end else begin
                  rsp_valid_in = 1'b0;
                  disp_in      = 1'b1;
                  disp_cnt_in  = '0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         disp_ff      <= 1'b0;
         disp_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         disp_ff      <= disp_in;
         disp_cnt_ff  <= disp_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      value_ff    <= value_in;
      position_ff <= position_in;
      last_ff     <= last_in;
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [31:0] prev_value;
      logic [31:0] next_value;
      if (g == 0) begin : g_head
         assign prev_value = req_value;
      end else begin : g_body
         assign prev_value = cell_value[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign next_value = '0;
      end else begin : g_inner
         assign next_value = cell_value[g+1];
      end
      olist_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (g)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .idx        (cell_idx),
         .count      (count_ff),
         .prev_value (prev_value),
         .next_value (next_value),
         .wrap_value (cell_value[0]),
         .value      (cell_value[g]),
         .match      (cell_match[g])
      );
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_value_out    = value_ff;
   assign rsp_position_out = position_ff;
   assign rsp_last         = last_ff;

endmodule
